// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define TCB_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TCB_ASSERT(lbl, clk, rstn, prop)
`define TCB_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// Types and constants shared by the TCB spline point generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcb_pkg;

    localparam int COORD_W    = 32;
    localparam int NUM_COORDS = 3;
    localparam int TWEEN_W    = 6;
    localparam int TCB_W      = 16;
    localparam int CC_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_TWEENS = 63;
    localparam int TCB_ONE    = 16384;

    localparam logic [TWEEN_W-1:0] TWEEN_RESET = 6'd16;
    localparam logic [CC_W-1:0]    CC_RESET    = 2'd3;

    // request kinds on s_tuser
    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_END   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TWEEN_COUNT = 3'd0,
        CFG_TENSION     = 3'd1,
        CFG_CONTINUITY  = 3'd2,
        CFG_BIAS        = 3'd3,
        CFG_COORD_COUNT = 3'd4
    } cfg_index_t;

    typedef logic [COORD_W-1:0] coord_t;
    typedef coord_t [NUM_COORDS-1:0] point_t;

    // segment only, segment followed by the closing point, single point
    typedef enum logic [1:0] {
        JOB_SEG,
        JOB_SEG_END,
        JOB_POINT
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        point_t    pa;
        point_t    pb;
        point_t    pc;
        point_t    pd;
    } job_t;

    typedef struct packed {
        logic [TWEEN_W-1:0] tween_count;
        logic [TCB_W-1:0]   tension;
        logic [TCB_W-1:0]   continuity;
        logic [TCB_W-1:0]   bias;
        logic [CC_W-1:0]    coord_count;
    } cfg_t;

endpackage

// ===== src/tcb_spline_point_generator.sv =====
// ----------------------------------------------------------------------------
// tcb_spline_point_generator
// Kochanek-Bartels (TCB) spline point generator, streaming in and out.
// ----------------------------------------------------------------------------
// Control points come in on the s_ channel (s_tuser low) and an end-of-list
// beat (s_tuser high) closes the curve. From the third point on, every point
// yields one segment of tween_count curve points on the m_ channel; the end
// beat yields the last segment and the final control point (m_tuser high).
// m_tlast marks the last point caused by one input beat. Work is done one
// job at a time on a single shared multiplier and a bit-serial basis divider:
// a segment first forms its tangent coefficients and tangents, then for each
// interpolated point its basis values (in the divider) and the point itself.
// A queue of QUEUE_DEPTH jobs lets the input run ahead of the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcb_spline_point_generator import tcb_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*COORD_W-1:0]  s_tdata,    // in_x, in_y, in_z
    input  logic                  s_tuser,    // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*COORD_W-1:0]  m_tdata,    // out_x, out_y, out_z
    output logic                  m_tlast,    // last_of_run
    output logic                  m_tuser,    // curve_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    logic push, q_full, q_pop, q_empty;
    job_t push_job, q_head;

    tcb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    tcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    tcb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== src/tcb_front.sv =====
// ----------------------------------------------------------------------------
// tcb_front
// Accepts control points, keeps the three-point window, holds the config
// registers and turns beats into segment or single-point jobs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcb_front import tcb_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*COORD_W-1:0]    s_tdata,
    input  logic                    s_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output cfg_t                    cfg,
    output logic                    push,
    output job_t                    push_job,
    input  logic                    q_full
);

    point_t      w0_reg, w1_reg, w2_reg;
    logic [1:0]  seen_reg, seen_next;
    cfg_t        cfg_reg;
    point_t      in_pt;
    logic        accept;

    assign in_pt     = s_tdata;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // classify the beat and build the job
    always_comb begin
        push      = 1'b0;
        push_job  = '0;
        seen_next = seen_reg;
        if (accept) begin
            case (s_tuser)
                REQ_POINT: begin
                    if (seen_reg >= 2'd2) begin
                        push          = 1'b1;
                        push_job.kind = JOB_SEG;
                        push_job.pa   = (seen_reg == 2'd3) ? w0_reg : w1_reg;
                        push_job.pb   = w1_reg;
                        push_job.pc   = w2_reg;
                        push_job.pd   = in_pt;
                    end
                    if (seen_reg != 2'd3) begin
                        seen_next = seen_reg + 2'd1;
                    end
                end
                REQ_END: begin
                    if (seen_reg == 2'd1) begin
                        push          = 1'b1;
                        push_job.kind = JOB_POINT;
                        push_job.pa   = w2_reg;
                        push_job.pb   = w2_reg;
                        push_job.pc   = w2_reg;
                        push_job.pd   = w2_reg;
                    end else if (seen_reg >= 2'd2) begin
                        push          = 1'b1;
                        push_job.kind = JOB_SEG_END;
                        push_job.pa   = (seen_reg == 2'd3) ? w0_reg : w1_reg;
                        push_job.pb   = w1_reg;
                        push_job.pc   = w2_reg;
                        push_job.pd   = w2_reg;
                    end
                    seen_next = 2'd0;
                end
                default: seen_next = seen_reg;
            endcase
        end
    end

    // window shift on control points
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == REQ_POINT) begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= in_pt;
        end
    end

    // fill count and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg            <= 2'd0;
            cfg_reg.tween_count <= TWEEN_RESET;
            cfg_reg.tension     <= '0;
            cfg_reg.continuity  <= '0;
            cfg_reg.bias        <= '0;
            cfg_reg.coord_count <= CC_RESET;
        end else begin
            seen_reg <= seen_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_TWEEN_COUNT: cfg_reg.tween_count <= cfg_data[TWEEN_W-1:0];
                    CFG_TENSION:     cfg_reg.tension     <= cfg_data[TCB_W-1:0];
                    CFG_CONTINUITY:  cfg_reg.continuity  <= cfg_data[TCB_W-1:0];
                    CFG_BIAS:        cfg_reg.bias        <= cfg_data[TCB_W-1:0];
                    CFG_COORD_COUNT: cfg_reg.coord_count <= cfg_data[CC_W-1:0];
                    default:         cfg_reg             <= cfg_reg;
                endcase
            end
        end
    end

endmodule

// ===== src/tcb_queue.sv =====
// ----------------------------------------------------------------------------
// tcb_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcb_queue import tcb_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `TCB_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && full)
    `TCB_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && empty)
    `TCB_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH))

endmodule

// ===== src/tcb_back.sv =====
// ----------------------------------------------------------------------------
// tcb_back
// Evaluates one job at a time: tangent coefficients, Hermite basis and points,
// on a shared multiplier and a bit-serial basis divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcb_back import tcb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  job_t                 q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*COORD_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    localparam int MA_W   = COORD_W + 8;   // tangents and accumulator
    localparam int MB_W   = 19;            // coefficients and basis values
    localparam int PR_W   = MA_W + MB_W;
    localparam int K_W    = 19;
    localparam int F_W    = TCB_W + 1;
    localparam int P_W    = 2 * F_W;
    localparam int D_W    = COORD_W + 1;
    localparam int NN_W   = 3 * TWEEN_W;
    localparam int NUM_W  = 3 * TWEEN_W;
    localparam int Q_W    = 17;
    localparam int REM_W  = NN_W;
    localparam int BQ     = 16;            // basis fraction bits
    localparam int TQ     = 14;            // tcb fraction bits
    localparam int CSH    = 29;            // coefficient shift
    localparam int DIVD_W = NUM_W + BQ + 1;
    localparam int CNT_W  = $clog2(Q_W);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WB, ST_DIV_INIT, ST_DIV, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_START, PH_TWEEN, PH_FINAL} phase_t;

    typedef enum logic [4:0] {
        OP_P1, OP_P2, OP_K0, OP_K1, OP_K2, OP_K3, OP_N2, OP_N3,
        OP_DS0, OP_DS1, OP_DD0, OP_DD1,
        OP_SS, OP_SM, OP_A2, OP_A3, OP_A4,
        OP_H2, OP_H3, OP_H4
    } op_t;

    state_t                    state_reg;
    phase_t                    phase_reg;
    op_t                       op_reg;
    logic [1:0]                j_reg;
    logic [TWEEN_W-1:0]        s_reg, n_reg;
    job_t                      job_reg;
    logic signed [P_W-1:0]     p1_reg, p2_reg;
    logic signed [K_W-1:0]     k_reg [4];
    logic [2*TWEEN_W-1:0]      nsq_reg, ss_reg, sm_reg;
    logic [NN_W-1:0]           nn_reg;
    logic signed [MA_W-1:0]    ds_reg [NUM_COORDS];
    logic signed [MA_W-1:0]    dd_reg [NUM_COORDS];
    logic signed [MA_W-1:0]    v_reg  [NUM_COORDS];
    logic signed [MA_W-1:0]    acc_reg;
    logic [NUM_W-1:0]          num_reg [3];
    logic [REM_W-1:0]          rem_reg [3];
    logic [Q_W-1:0]            lo_reg  [3];
    logic [Q_W-1:0]            q_reg   [3];
    logic [CNT_W-1:0]          div_cnt_reg;
    logic signed [PR_W-1:0]    prod_reg;
    logic                      m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [3*COORD_W-1:0]      m_tdata_reg;

    logic signed [F_W-1:0]     ft, fcp, fcm, fbp, fbm;
    logic signed [D_W-1:0]     d0, d1, d2;
    logic signed [MA_W-1:0]    pb_j;
    logic [TWEEN_W-1:0]        nms;
    logic [TWEEN_W+2:0]        tn2s;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PR_W-1:0]    prod_r14, prod_r16, prod_coef;
    logic [REM_W:0]            rem2 [3];
    logic                      ge   [3];
    logic [DIVD_W-1:0]         divd [3];
    logic [CC_W-1:0]           cc_eff;
    point_t                    out_pt;
    logic                      emit_last, emit_end, out_free, seg_tail;
    logic [TWEEN_W-1:0]        n_load;

    // TCB factor pairs
    assign ft  = F_W'(TCB_ONE) - F_W'($signed(cfg.tension));
    assign fcp = F_W'(TCB_ONE) + F_W'($signed(cfg.continuity));
    assign fcm = F_W'(TCB_ONE) - F_W'($signed(cfg.continuity));
    assign fbp = F_W'(TCB_ONE) + F_W'($signed(cfg.bias));
    assign fbm = F_W'(TCB_ONE) - F_W'($signed(cfg.bias));

    // coordinate differences for the current lane
    assign d0   = D_W'($signed(job_reg.pb[j_reg])) - D_W'($signed(job_reg.pa[j_reg]));
    assign d1   = D_W'($signed(job_reg.pc[j_reg])) - D_W'($signed(job_reg.pb[j_reg]));
    assign d2   = D_W'($signed(job_reg.pd[j_reg])) - D_W'($signed(job_reg.pc[j_reg]));
    assign pb_j = MA_W'($signed(job_reg.pb[j_reg]));
    assign nms  = n_reg - s_reg;
    assign tn2s = (TWEEN_W+3)'(n_reg) * (TWEEN_W+3)'(3) - (TWEEN_W+3)'(s_reg) * (TWEEN_W+3)'(2);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_P1:  begin mul_a = MA_W'(ft);      mul_b = MB_W'(fcp); end
            OP_P2:  begin mul_a = MA_W'(ft);      mul_b = MB_W'(fcm); end
            OP_K0:  begin mul_a = MA_W'(p1_reg);  mul_b = MB_W'(fbp); end
            OP_K1:  begin mul_a = MA_W'(p2_reg);  mul_b = MB_W'(fbm); end
            OP_K2:  begin mul_a = MA_W'(p2_reg);  mul_b = MB_W'(fbp); end
            OP_K3:  begin mul_a = MA_W'(p1_reg);  mul_b = MB_W'(fbm); end
            OP_N2:  begin mul_a = MA_W'(n_reg);   mul_b = MB_W'(n_reg); end
            OP_N3:  begin mul_a = MA_W'(nsq_reg); mul_b = MB_W'(n_reg); end
            OP_DS0: begin mul_a = MA_W'(d0);      mul_b = MB_W'(k_reg[0]); end
            OP_DS1: begin mul_a = MA_W'(d1);      mul_b = MB_W'(k_reg[1]); end
            OP_DD0: begin mul_a = MA_W'(d1);      mul_b = MB_W'(k_reg[2]); end
            OP_DD1: begin mul_a = MA_W'(d2);      mul_b = MB_W'(k_reg[3]); end
            OP_SS:  begin mul_a = MA_W'(s_reg);   mul_b = MB_W'(s_reg); end
            OP_SM:  begin mul_a = MA_W'(s_reg);   mul_b = MB_W'(nms); end
            OP_A2:  begin mul_a = MA_W'(ss_reg);  mul_b = MB_W'(tn2s); end
            OP_A3:  begin mul_a = MA_W'(sm_reg);  mul_b = MB_W'(nms); end
            OP_A4:  begin mul_a = MA_W'(ss_reg);  mul_b = MB_W'(nms); end
            OP_H2:  begin mul_a = MA_W'(d1);            mul_b = MB_W'(q_reg[0]); end
            OP_H3:  begin mul_a = ds_reg[j_reg];        mul_b = MB_W'(q_reg[1]); end
            OP_H4:  begin mul_a = dd_reg[j_reg];        mul_b = MB_W'(0) - MB_W'(q_reg[2]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // rounded views of the product
    assign prod_r14  = (prod_reg + PR_W'(1 << (TQ - 1))) >>> TQ;
    assign prod_r16  = (prod_reg + PR_W'(1 << (BQ - 1))) >>> BQ;
    assign prod_coef = (prod_reg + PR_W'(1 << (CSH - 1))) >>> CSH;

    // basis divider steps, three in parallel
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            divd[i] = (DIVD_W'(num_reg[i]) << BQ) + DIVD_W'(nn_reg >> 1);
            rem2[i] = {rem_reg[i], lo_reg[i][Q_W-1]};
            ge[i]   = (rem2[i] >= (REM_W+1)'(nn_reg));
        end
    end

    // output point assembly
    assign cc_eff   = (cfg.coord_count == '0) ? CC_W'(1) : cfg.coord_count;
    assign seg_tail = (phase_reg == PH_START && n_reg == TWEEN_W'(1))
                   || (phase_reg == PH_TWEEN && s_reg == n_reg - TWEEN_W'(1));
    assign emit_end  = (phase_reg == PH_FINAL) || (job_reg.kind == JOB_POINT);
    assign emit_last = emit_end || (job_reg.kind == JOB_SEG && seg_tail);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign n_load    = (cfg.tween_count == '0) ? TWEEN_W'(1)
                     : (cfg.tween_count > TWEEN_W'(MAX_TWEENS)) ? TWEEN_W'(MAX_TWEENS)
                     : cfg.tween_count;

    always_comb begin
        for (int i = 0; i < NUM_COORDS; i++) begin
            if (CC_W'(i) >= cc_eff) begin
                out_pt[i] = '0;
            end else if (v_reg[i][MA_W-1:COORD_W-1] == '0
                      || v_reg[i][MA_W-1:COORD_W-1] == '1) begin
                out_pt[i] = v_reg[i][COORD_W-1:0];
            end else if (v_reg[i][MA_W-1]) begin
                out_pt[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                out_pt[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_START;
            op_reg       <= OP_P1;
            m_tvalid_reg <= 1'b0;
        end else begin
            // beat taken and no new one loaded this cycle
            if (m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_head;
                        n_reg     <= n_load;
                        phase_reg <= PH_START;
                        for (int i = 0; i < NUM_COORDS; i++) begin
                            v_reg[i] <= MA_W'($signed(q_head.pb[i]));
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_ISSUE: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    state_reg <= ST_ISSUE;
                    case (op_reg)
                        OP_P1: begin p1_reg <= P_W'(prod_reg); op_reg <= OP_P2; end
                        OP_P2: begin p2_reg <= P_W'(prod_reg); op_reg <= OP_K0; end
                        OP_K0: begin k_reg[0] <= K_W'(prod_coef); op_reg <= OP_K1; end
                        OP_K1: begin k_reg[1] <= K_W'(prod_coef); op_reg <= OP_K2; end
                        OP_K2: begin k_reg[2] <= K_W'(prod_coef); op_reg <= OP_K3; end
                        OP_K3: begin k_reg[3] <= K_W'(prod_coef); op_reg <= OP_N2; end
                        OP_N2: begin nsq_reg <= (2*TWEEN_W)'(prod_reg); op_reg <= OP_N3; end
                        OP_N3: begin
                            nn_reg <= NN_W'(prod_reg);
                            j_reg  <= 2'd0;
                            op_reg <= OP_DS0;
                        end
                        OP_DS0: begin ds_reg[j_reg] <= MA_W'(prod_r14); op_reg <= OP_DS1; end
                        OP_DS1: begin
                            ds_reg[j_reg] <= ds_reg[j_reg] + MA_W'(prod_r14);
                            op_reg        <= OP_DD0;
                        end
                        OP_DD0: begin dd_reg[j_reg] <= MA_W'(prod_r14); op_reg <= OP_DD1; end
                        OP_DD1: begin
                            dd_reg[j_reg] <= dd_reg[j_reg] + MA_W'(prod_r14);
                            if (j_reg == 2'(NUM_COORDS - 1)) begin
                                s_reg  <= TWEEN_W'(1);
                                op_reg <= OP_SS;
                            end else begin
                                j_reg  <= j_reg + 2'd1;
                                op_reg <= OP_DS0;
                            end
                        end
                        OP_SS: begin ss_reg <= (2*TWEEN_W)'(prod_reg); op_reg <= OP_SM; end
                        OP_SM: begin sm_reg <= (2*TWEEN_W)'(prod_reg); op_reg <= OP_A2; end
                        OP_A2: begin num_reg[0] <= NUM_W'(prod_reg); op_reg <= OP_A3; end
                        OP_A3: begin num_reg[1] <= NUM_W'(prod_reg); op_reg <= OP_A4; end
                        OP_A4: begin
                            num_reg[2] <= NUM_W'(prod_reg);
                            state_reg  <= ST_DIV_INIT;
                        end
                        OP_H2: begin acc_reg <= pb_j + MA_W'(prod_r16); op_reg <= OP_H3; end
                        OP_H3: begin acc_reg <= acc_reg + MA_W'(prod_r16); op_reg <= OP_H4; end
                        OP_H4: begin
                            v_reg[j_reg] <= acc_reg + MA_W'(prod_r16);
                            if (j_reg == 2'(NUM_COORDS - 1)) begin
                                phase_reg <= PH_TWEEN;
                                state_reg <= ST_EMIT;
                            end else begin
                                j_reg  <= j_reg + 2'd1;
                                op_reg <= OP_H2;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_DIV_INIT: begin
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[i] <= divd[i][DIVD_W-1:Q_W];
                        lo_reg[i]  <= divd[i][Q_W-1:0];
                        q_reg[i]   <= '0;
                    end
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (ge[i]) begin
                            rem_reg[i] <= REM_W'(rem2[i] - (REM_W+1)'(nn_reg));
                        end else begin
                            rem_reg[i] <= rem2[i][REM_W-1:0];
                        end
                        q_reg[i]  <= {q_reg[i][Q_W-2:0], ge[i]};
                        lo_reg[i] <= lo_reg[i] << 1;
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_W'(Q_W - 1)) begin
                        j_reg     <= 2'd0;
                        op_reg    <= OP_H2;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= out_pt;
                        m_tlast_reg  <= emit_last;
                        m_tuser_reg  <= emit_end;
                        if (phase_reg == PH_FINAL || job_reg.kind == JOB_POINT) begin
                            state_reg <= ST_IDLE;
                        end else if (seg_tail) begin
                            // segment done: closing point or next job
                            if (job_reg.kind == JOB_SEG_END) begin
                                for (int i = 0; i < NUM_COORDS; i++) begin
                                    v_reg[i] <= MA_W'($signed(job_reg.pc[i]));
                                end
                                phase_reg <= PH_FINAL;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end else if (phase_reg == PH_START) begin
                            op_reg    <= OP_P1;
                            state_reg <= ST_ISSUE;
                        end else begin
                            s_reg     <= s_reg + TWEEN_W'(1);
                            op_reg    <= OP_SS;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TCB_ASSERT(a_tween_range, aclk, aresetn, (state_reg != ST_IDLE && phase_reg == PH_TWEEN) |-> (s_reg != '0 && s_reg < n_reg))
    `TCB_ASSERT(a_out_from_emit, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
    `TCB_ASSERT(a_div_len, aclk, aresetn, (state_reg == ST_DIV) |-> (div_cnt_reg < CNT_W'(Q_W)))

endmodule

// ===== dv/tcb_spline_point_generator_tb.sv =====
// ----------------------------------------------------------------------------
// tcb_spline_point_generator_tb
// Streams control-point lists through the TCB spline generator under random
// gaps and back-pressure, predicts every curve point and checks each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcb_spline_point_generator_tb;
    import tcb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 4000;
    localparam int DRAIN_CYCLES   = 3200;

    typedef struct {
        coord_t x, y, z;
        bit     run_last;
        bit     curve_end;
    } curve_pt_t;

    // Spline predictor and queue of curve points still due
    class spline_scoreboard;
        longint    win [3][3];
        int        seen;
        int        tween_count;
        longint    tension, continuity, bias;
        int        coord_count;
        curve_pt_t due_points[$];
        int        errors;
        int        checked;

        function new();
            tween_count = 16;
            tension = 0;
            continuity = 0;
            bias = 0;
            coord_count = 3;
            seen = 0;
            errors = 0;
            checked = 0;
            foreach (win[i, j]) win[i][j] = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                CFG_TWEEN_COUNT: tween_count = val[5:0];
                CFG_TENSION:     tension = longint'(signed'(val));
                CFG_CONTINUITY:  continuity = longint'(signed'(val));
                CFG_BIAS:        bias = longint'(signed'(val));
                CFG_COORD_COUNT: coord_count = val[1:0];
                default: ;
            endcase
        endfunction

        // round(c*v / 2^q), half up, split to keep products small
        function longint mul_rnd(longint c, longint v, int q);
            longint vh, vl;
            vh = v >>> q;
            vl = v - (vh <<< q);
            return c * vh + ((c * vl + (longint'(1) <<< (q - 1))) >>> q);
        endfunction

        function longint tcb_coef(longint a, longint b, longint c);
            return (a * b * c + (longint'(1) <<< 28)) >>> 29;
        endfunction

        function coord_t clamp(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void push_pt(longint v [3]);
            curve_pt_t p;
            int cc;
            cc = (coord_count == 0) ? 1 : coord_count;
            p.x = clamp(v[0]);
            p.y = (cc > 1) ? clamp(v[1]) : '0;
            p.z = (cc > 2) ? clamp(v[2]) : '0;
            p.run_last = 0;
            p.curve_end = 0;
            due_points.push_back(p);
        endfunction

        function void segment(longint pa [3], longint pb [3], longint pc [3],
                              longint pd [3]);
            longint one, ft, kds1, kds2, kdd1, kdd2, nn, si, ni, h2, h3, h4;
            longint d0, d1, d2, ds, dd;
            longint v [3];
            int n;
            n = (tween_count == 0) ? 1 : tween_count;
            one = TCB_ONE;
            ft = one - tension;
            kds1 = tcb_coef(ft, one + continuity, one + bias);
            kds2 = tcb_coef(ft, one - continuity, one - bias);
            kdd1 = tcb_coef(ft, one - continuity, one + bias);
            kdd2 = tcb_coef(ft, one + continuity, one - bias);
            ni = n;
            nn = ni * ni * ni;
            push_pt(pb);
            for (int s = 1; s < n; s++) begin
                si = s;
                h2 = (65536 * (si * si * (3 * ni - 2 * si)) + nn / 2) / nn;
                h3 = (65536 * (si * (ni - si) * (ni - si)) + nn / 2) / nn;
                h4 = -((65536 * (si * si * (ni - si)) + nn / 2) / nn);
                for (int j = 0; j < 3; j++) begin
                    d0 = pb[j] - pa[j];
                    d1 = pc[j] - pb[j];
                    d2 = pd[j] - pc[j];
                    ds = mul_rnd(kds1, d0, 14) + mul_rnd(kds2, d1, 14);
                    dd = mul_rnd(kdd1, d1, 14) + mul_rnd(kdd2, d2, 14);
                    v[j] = pb[j] + mul_rnd(h2, d1, 16) + mul_rnd(h3, ds, 16)
                         + mul_rnd(h4, dd, 16);
                end
                push_pt(v);
            end
        endfunction

        // One accepted input beat: extend the expected curve
        function void note_input(logic req, coord_t x, coord_t y, coord_t z);
            longint c [3];
            int prev_size;
            prev_size = due_points.size();
            if (req == REQ_POINT) begin
                c[0] = longint'(signed'(x));
                c[1] = longint'(signed'(y));
                c[2] = longint'(signed'(z));
                if (seen == 3) segment(win[0], win[1], win[2], c);
                else if (seen == 2) segment(win[1], win[1], win[2], c);
                win[0] = win[1];
                win[1] = win[2];
                win[2] = c;
                if (seen < 3) seen++;
            end else begin
                if (seen == 0) return;
                if (seen == 3) segment(win[0], win[1], win[2], win[2]);
                else if (seen == 2) segment(win[1], win[1], win[2], win[2]);
                push_pt(win[2]);
                due_points[$].curve_end = 1;
                foreach (win[i, j]) win[i][j] = 0;
                seen = 0;
            end
            if (due_points.size() > prev_size) due_points[$].run_last = 1;
        endfunction

        function void check_result(logic [3*COORD_W-1:0] d, logic tl, logic tu);
            curve_pt_t e;
            if (due_points.size() == 0) begin
                $display("%0t: unexpected curve point, actual %h last %b end %b",
                         $time, d, tl, tu);
                errors++;
                return;
            end
            e = due_points.pop_front();
            checked++;
            if (d[31:0] !== e.x) begin
                $display("%0t: out_x expected %h actual %h", $time, e.x, d[31:0]);
                errors++;
            end
            if (d[63:32] !== e.y) begin
                $display("%0t: out_y expected %h actual %h", $time, e.y, d[63:32]);
                errors++;
            end
            if (d[95:64] !== e.z) begin
                $display("%0t: out_z expected %h actual %h", $time, e.z, d[95:64]);
                errors++;
            end
            if (tl !== e.run_last) begin
                $display("%0t: last_of_run expected %b actual %b", $time, e.run_last, tl);
                errors++;
            end
            if (tu !== e.curve_end) begin
                $display("%0t: curve_end expected %b actual %b", $time, e.curve_end, tu);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [3*COORD_W-1:0]  s_tdata;    // in_x, in_y, in_z
    logic                  s_tuser;    // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [3*COORD_W-1:0]  m_tdata;    // out_x, out_y, out_z
    logic                  m_tlast;    // last_of_run
    logic                  m_tuser;    // curve_end
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spline_scoreboard sb = new();
    int  beats_in;
    int  curve_beats;
    int  idle_cycles;
    bit  held_long;

    tcb_spline_point_generator DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Input and output monitors, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
                beats_in++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast, m_tuser);
                curve_beats++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d points outstanding",
                         $time, sb.due_points.size());
                $display("tcb_spline_point_generator_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off once the curve is flowing
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            int gap;
            if (!held_long && curve_beats >= 400) begin
                held_long = 1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_beat(logic req, coord_t x, coord_t y, coord_t z, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every due point, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.due_points.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 6))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    task automatic send_list(int npts, bit bursty);
        for (int i = 0; i < npts; i++)
            send_beat(REQ_POINT, pick_coord(), pick_coord(), pick_coord(),
                      bursty && $urandom_range(0, 1));
        send_beat(REQ_END, pick_coord(), pick_coord(), pick_coord(), 0);
    endtask

    task automatic set_shape(logic [15:0] t, logic [15:0] c, logic [15:0] b);
        write_reg(CFG_TENSION, t);
        write_reg(CFG_CONTINUITY, c);
        write_reg(CFG_BIAS, b);
    endtask

    int tweens [8] = '{4, 1, 7, 0, 3, 63, 6, 2};

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_POINT;
        cfg_valid = 1'b0;
        cfg_index = CFG_TWEEN_COUNT;
        cfg_data  = '0;
        beats_in = 0;
        curve_beats = 0;
        idle_cycles = 0;
        held_long = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, one point, two points, then extremes
        send_beat(REQ_END, '0, '0, '0, 0);
        send_beat(REQ_POINT, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 0);
        send_beat(REQ_END, '0, '0, '0, 0);
        send_beat(REQ_POINT, 32'h8000_0000, 32'h7fff_ffff, '0, 0);
        send_beat(REQ_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
        send_beat(REQ_END, '1, '1, '1, 0);
        send_beat(REQ_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_beat(REQ_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        send_beat(REQ_POINT, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 1);
        send_beat(REQ_POINT, 32'h7fff_ffff, 32'hffff_fffe, 32'h8000_0000, 0);
        send_beat(REQ_END, '0, '0, '0, 0);
        drain();
        // shape extremes and out-of-range register values
        write_reg(CFG_TWEEN_COUNT, 16'd3);
        write_reg(CFG_COORD_COUNT, 16'd0);
        set_shape(16'h8000, 16'h7fff, 16'hc000);
        send_list(4, 0);
        drain();
        write_reg(CFG_COORD_COUNT, 16'd2);
        set_shape(16'd16384, 16'hc000, 16'd16384);
        send_list(3, 0);
        drain();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            int budget;
            write_reg(CFG_TWEEN_COUNT, 16'(tweens[ph]) | 16'($urandom_range(0, 3) << 6));
            write_reg(CFG_COORD_COUNT, 16'($urandom_range(0, 3)));
            case (ph % 4)
                0:       set_shape(16'hc000, 16'd16384, 16'hc000);
                1:       set_shape(16'($urandom), 16'($urandom), 16'($urandom));
                2:       set_shape(16'($urandom_range(0, 32768) - 16384),
                                   16'($urandom_range(0, 32768) - 16384),
                                   16'($urandom_range(0, 32768) - 16384));
                default: set_shape(16'd0, 16'd0, 16'd0);
            endcase
            budget = (tweens[ph] == 63) ? 10 : 60;
            while (budget > 0) begin
                int npts;
                case ($urandom_range(0, 9))
                    0:       npts = $urandom_range(0, 2);   // short or broken lists
                    default: npts = $urandom_range(3, 9);
                endcase
                if (tweens[ph] == 63) npts = 3;
                send_list(npts, 1);
                budget -= npts + 1;
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d input beats and %0d curve points over 11 register settings",
                 beats_in, sb.checked);
        if (sb.errors == 0 && sb.due_points.size() == 0) begin
            $display("tcb_spline_point_generator_tb: done, clean");
        end else begin
            $display("tcb_spline_point_generator_tb: done, errors");
        end
        $finish;
    end

endmodule
